FILE: design/wsfd_pkg.sv
package wsfd_pkg;

    // Queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Header length codes
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_TOO_BIG = 7'd127;

    // Index of the last mask key byte
    localparam logic [1:0] KEY_LAST = 2'd3;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXTHI = 3'd2,
        PH_EXTLO = 3'd3,
        PH_MASK  = 3'd4,
        PH_DATA  = 3'd5,
        PH_SKIP  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_BIG   = 2'd2,
        ST_TRUNC = 2'd3
    } t_status;

    // One result word on its way from parser to output stage
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       byte_valid;
        logic       final_flag;
        logic [3:0] opcode;
        t_status    status;
        logic       done;
    } t_entry;

endpackage

FILE: design/wsfd_front.sv
module wsfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_chunk_end,
    output logic            o_push,
    output wsfd_pkg::t_entry o_entry
);
    import wsfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [15:0] r_len, n_len;
    logic [15:0] r_idx, n_idx;
    logic [7:0]  r_key [4];

    logic        key_we;
    logic        emit;
    logic        go_after;
    logic        go_begin;
    logic        masked_now;
    logic [15:0] len_now;
    logic [15:0] idx_inc;
    logic [6:0]  code;
    logic        last;
    t_entry      e;

    assign last    = i_chunk_end;
    assign code    = i_rx_byte[6:0];
    assign idx_inc = r_idx + 16'd1;

    // Parse one word against the current header phase
    always_comb begin
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_opcode   = r_opcode;
        n_masked   = r_masked;
        n_len      = r_len;
        n_idx      = r_idx;
        key_we     = 1'b0;
        emit       = 1'b0;
        go_after   = 1'b0;
        go_begin   = 1'b0;
        masked_now = r_masked;
        len_now    = r_len;
        e.data       = 8'h00;
        e.key        = 8'h00;
        e.byte_valid = 1'b0;
        e.status     = ST_OK;
        e.done       = 1'b0;

        unique case (r_phase)
            PH_HDR0: begin
                n_fin    = i_rx_byte[7];
                n_opcode = i_rx_byte[3:0];
                if (last) begin
                    emit     = 1'b1;
                    e.status = ST_SHORT;
                    e.done   = 1'b1;
                    n_phase  = PH_HDR0;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            PH_HDR1: begin
                n_masked = i_rx_byte[7];
                if (code == LEN_TOO_BIG) begin
                    emit     = 1'b1;
                    e.status = ST_BIG;
                    e.done   = 1'b1;
                    n_phase  = last ? PH_HDR0 : PH_SKIP;
                end else if (code == LEN_EXT16) begin
                    if (last) begin
                        emit     = 1'b1;
                        e.status = ST_TRUNC;
                        e.done   = 1'b1;
                        n_phase  = PH_HDR0;
                    end else begin
                        n_phase = PH_EXTHI;
                    end
                end else begin
                    len_now    = {9'd0, code};
                    n_len      = len_now;
                    masked_now = i_rx_byte[7];
                    go_after   = 1'b1;
                end
            end
            PH_EXTHI: begin
                n_len = {i_rx_byte, 8'h00};
                if (last) begin
                    emit     = 1'b1;
                    e.status = ST_TRUNC;
                    e.done   = 1'b1;
                    n_phase  = PH_HDR0;
                end else begin
                    n_phase = PH_EXTLO;
                end
            end
            PH_EXTLO: begin
                len_now  = {r_len[15:8], i_rx_byte};
                n_len    = len_now;
                go_after = 1'b1;
            end
            PH_MASK: begin
                key_we = 1'b1;
                n_idx  = idx_inc;
                if (r_idx[1:0] == KEY_LAST) begin
                    go_begin = 1'b1;
                end else if (last) begin
                    emit     = 1'b1;
                    e.status = ST_TRUNC;
                    e.done   = 1'b1;
                    n_phase  = PH_HDR0;
                end
            end
            PH_DATA: begin
                emit         = 1'b1;
                e.data       = i_rx_byte;
                e.key        = r_masked ? r_key[r_idx[1:0]] : 8'h00;
                e.byte_valid = 1'b1;
                n_idx        = idx_inc;
                if (idx_inc >= r_len) begin
                    e.done  = 1'b1;
                    n_phase = last ? PH_HDR0 : PH_SKIP;
                end else if (last) begin
                    e.status = ST_TRUNC;
                    e.done   = 1'b1;
                    n_phase  = PH_HDR0;
                end
            end
            PH_SKIP: begin
                n_phase = last ? PH_HDR0 : PH_SKIP;
            end
            default: begin
                n_phase = PH_HDR0;
            end
        endcase

        // Length known: collect the key or enter the payload
        if (go_after) begin
            if (masked_now) begin
                n_idx = 16'd0;
                if (last) begin
                    emit     = 1'b1;
                    e.status = ST_TRUNC;
                    e.done   = 1'b1;
                    n_phase  = PH_HDR0;
                end else begin
                    n_phase = PH_MASK;
                end
            end else begin
                go_begin = 1'b1;
            end
        end

        // Header complete: enter the payload or close an empty frame
        if (go_begin) begin
            n_idx = 16'd0;
            if (len_now == 16'd0) begin
                emit     = 1'b1;
                e.status = ST_OK;
                e.done   = 1'b1;
                n_phase  = last ? PH_HDR0 : PH_SKIP;
            end else if (last) begin
                emit     = 1'b1;
                e.status = ST_TRUNC;
                e.done   = 1'b1;
                n_phase  = PH_HDR0;
            end else begin
                n_phase = PH_DATA;
            end
        end

        e.final_flag = n_fin;
        e.opcode     = n_opcode;
    end

    assign o_push  = i_accept & emit;
    assign o_entry = e;

    // Hold parse state; advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_fin    <= 1'b0;
            r_opcode <= 4'h0;
            r_masked <= 1'b0;
            r_len    <= 16'd0;
            r_idx    <= 16'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_idx    <= n_idx;
        end
    end

    // Mask key bytes
    always_ff @(posedge i_clk) begin
        if (i_accept && key_we) begin
            r_key[r_idx[1:0]] <= i_rx_byte;
        end
    end

endmodule

FILE: design/wsfd_queue.sv
module wsfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsfd_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_avail,
    output wsfd_pkg::t_entry o_entry
);
    import wsfd_pkg::*;

    t_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, r_rd;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  do_push, do_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_avail;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

FILE: design/wsfd_back.sv
module wsfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  wsfd_pkg::t_entry i_entry,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [7:0]       o_payload_byte,
    output logic             o_byte_valid,
    output logic             o_final_flag,
    output logic [3:0]       o_frame_opcode,
    output logic [1:0]       o_status,
    output logic             o_frame_done
);
    import wsfd_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_byte_valid;
    logic       r_fin;
    logic [3:0] r_opcode;
    t_status    r_status;
    logic       r_done;

    // Take the next word when the output register is empty or drains
    assign o_pop = i_avail & (~r_valid | i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Unmask payload into the output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data       <= i_entry.data ^ i_entry.key;
            r_byte_valid <= i_entry.byte_valid;
            r_fin        <= i_entry.final_flag;
            r_opcode     <= i_entry.opcode;
            r_status     <= i_entry.status;
            r_done       <= i_entry.done;
        end
    end

    assign o_valid        = r_valid;
    assign o_payload_byte = r_data;
    assign o_byte_valid   = r_byte_valid;
    assign o_final_flag   = r_fin;
    assign o_frame_opcode = r_opcode;
    assign o_status       = r_status;
    assign o_frame_done   = r_done;

endmodule

FILE: design/websocket_frame_decoder.sv
// Channel   Valid     Ready     Word
// input     i_valid   o_ready   i_rx_byte, i_chunk_end
// output    o_valid   i_ready   o_payload_byte, o_byte_valid, o_final_flag,
//                               o_frame_opcode, o_status, o_frame_done
//
// One byte is taken per cycle while the queue is not full; a result goes from
// the parser into a 4-word queue, then through the unmasking output register.
// Synchronous active-low reset returns the parser to the first header byte
// and empties the queue; there is no clearing pass.
// o_ready drops only while the queue is full, so a stalled output holds
// input back after four pending results plus the one in the output register.
module websocket_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_chunk_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_byte_valid,
    output logic       o_final_flag,
    output logic [3:0] o_frame_opcode,
    output logic [1:0] o_status,
    output logic       o_frame_done
);
    import wsfd_pkg::*;

    logic   accept;
    logic   push;
    logic   full;
    logic   pop;
    logic   avail;
    t_entry front_entry;
    t_entry queue_entry;

    assign o_ready = ~full;
    assign accept  = i_valid & o_ready;

    wsfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_chunk_end (i_chunk_end),
        .o_push      (push),
        .o_entry     (front_entry)
    );

    wsfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_entry (queue_entry)
    );

    wsfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (avail),
        .i_entry        (queue_entry),
        .o_pop          (pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_payload_byte (o_payload_byte),
        .o_byte_valid   (o_byte_valid),
        .o_final_flag   (o_final_flag),
        .o_frame_opcode (o_frame_opcode),
        .o_status       (o_status),
        .o_frame_done   (o_frame_done)
    );

    // A result without a byte carries zero data
    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_payload_byte == 8'h00)
        else $error("data word without byte_valid is not zero");

    // A result that does not close the frame always carries a byte
    a_open_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_done |-> o_byte_valid)
        else $error("open frame result without payload byte");

    // Error results close the frame and carry no byte, except truncation
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_SHORT || o_status == ST_BIG)
        |-> o_frame_done && !o_byte_valid)
        else $error("short or big frame result malformed");

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

FILE: sim/websocket_frame_decoder_tb.sv
module websocket_frame_decoder_tb;

    import wsfd_pkg::*;

    localparam int IDLE_PCT   = 27;
    localparam int RAND_BYTES = 800;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 80;
    localparam int CALM_FROM  = 450;
    localparam int CALM_TO    = 620;
    localparam int PAUSE_GAP  = 150;
    localparam int WAIT_LIMIT = 1000;
    localparam int PRINT_MAX  = 50;

    typedef logic [7:0] t_byte_list [$];

    // One byte waiting to be offered, with an optional drain-first mark
    typedef struct {
        logic [7:0] rx_byte;
        logic       last;
        bit         pause;
    } t_rx_item;

    // One decoded word as it should leave the block
    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       fin;
        logic [3:0] opcode;
        t_status    status;
        logic       done;
    } t_decoded;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_chunk_end = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_payload_byte;
    logic       o_byte_valid;
    logic       o_final_flag;
    logic [3:0] o_frame_opcode;
    logic [1:0] o_status;
    logic       o_frame_done;

    t_rx_item rx_pending [$];
    t_decoded decoded_words [$];
    t_rx_item next_item;
    t_decoded want;

    logic byte_taken = 1'b0;
    int   bytes_in = 0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    bit   hold_done = 1'b0;
    logic calm;

    // Decoder state as predicted
    t_phase     parse_at = PH_HDR0;
    logic       hdr_fin = 1'b0;
    logic [3:0] hdr_opcode = 4'h0;
    logic       key_on = 1'b0;
    logic [15:0] frame_len = 16'h0000;
    logic [7:0] key_bytes [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [15:0] byte_count = 16'h0000;

    assign calm = (bytes_in >= CALM_FROM) && (bytes_in < CALM_TO);

    websocket_frame_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .i_chunk_end    (i_chunk_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_payload_byte (o_payload_byte),
        .o_byte_valid   (o_byte_valid),
        .o_final_flag   (o_final_flag),
        .o_frame_opcode (o_frame_opcode),
        .o_status       (o_status),
        .o_frame_done   (o_frame_done)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        if (mismatches < PRINT_MAX) begin
            $display("ERROR cycle-byte %0d: %s", bytes_in, msg);
        end
        mismatches++;
    endtask

    // Queue one decoded word with the current header fields
    task automatic push_word(input logic [7:0] data, input logic valid, input t_status st,
                             input logic done);
        t_decoded w;
        w.data   = valid ? data : 8'h00;
        w.valid  = valid;
        w.fin    = hdr_fin;
        w.opcode = hdr_opcode;
        w.status = st;
        w.done   = done;
        decoded_words.insert(decoded_words.size(), w);
    endtask

    // Header complete: enter the payload or close an empty frame
    task automatic enter_payload(input logic last);
        byte_count = 16'h0000;
        if (frame_len == 16'h0000) begin
            parse_at = last ? PH_HDR0 : PH_SKIP;
            push_word(8'h00, 1'b0, ST_OK, 1'b1);
        end else if (last) begin
            parse_at = PH_HDR0;
            push_word(8'h00, 1'b0, ST_TRUNC, 1'b1);
        end else begin
            parse_at = PH_DATA;
        end
    endtask

    // Length known: collect the key when masked
    task automatic length_known(input logic last);
        if (key_on) begin
            byte_count = 16'h0000;
            if (last) begin
                parse_at = PH_HDR0;
                push_word(8'h00, 1'b0, ST_TRUNC, 1'b1);
            end else begin
                parse_at = PH_MASK;
            end
        end else begin
            enter_payload(last);
        end
    endtask

    // Advance the predicted parser by one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [7:0] d;
        case (parse_at)
            PH_HDR0: begin
                hdr_fin    = b[7];
                hdr_opcode = b[3:0];
                if (last) begin
                    parse_at = PH_HDR0;
                    push_word(8'h00, 1'b0, ST_SHORT, 1'b1);
                end else begin
                    parse_at = PH_HDR1;
                end
            end
            PH_HDR1: begin
                key_on = b[7];
                if (b[6:0] == LEN_TOO_BIG) begin
                    parse_at = last ? PH_HDR0 : PH_SKIP;
                    push_word(8'h00, 1'b0, ST_BIG, 1'b1);
                end else if (b[6:0] == LEN_EXT16) begin
                    if (last) begin
                        parse_at = PH_HDR0;
                        push_word(8'h00, 1'b0, ST_TRUNC, 1'b1);
                    end else begin
                        parse_at = PH_EXTHI;
                    end
                end else begin
                    frame_len = {9'd0, b[6:0]};
                    length_known(last);
                end
            end
            PH_EXTHI: begin
                frame_len = {b, 8'h00};
                if (last) begin
                    parse_at = PH_HDR0;
                    push_word(8'h00, 1'b0, ST_TRUNC, 1'b1);
                end else begin
                    parse_at = PH_EXTLO;
                end
            end
            PH_EXTLO: begin
                frame_len = frame_len | {8'h00, b};
                length_known(last);
            end
            PH_MASK: begin
                key_bytes[byte_count[1:0]] = b;
                byte_count = byte_count + 16'd1;
                if (byte_count >= 16'd4) begin
                    enter_payload(last);
                end else if (last) begin
                    parse_at = PH_HDR0;
                    push_word(8'h00, 1'b0, ST_TRUNC, 1'b1);
                end
            end
            PH_DATA: begin
                d = key_on ? (b ^ key_bytes[byte_count[1:0]]) : b;
                byte_count = byte_count + 16'd1;
                if (byte_count >= frame_len) begin
                    parse_at = last ? PH_HDR0 : PH_SKIP;
                    push_word(d, 1'b1, ST_OK, 1'b1);
                end else if (last) begin
                    parse_at = PH_HDR0;
                    push_word(d, 1'b1, ST_TRUNC, 1'b1);
                end else begin
                    push_word(d, 1'b1, ST_OK, 1'b0);
                end
            end
            default: begin
                parse_at = last ? PH_HDR0 : PH_SKIP;
            end
        endcase
    endtask

    // Queue one chunk, marking its last byte and, if asked, its first as drain-first
    task automatic add_chunk(input t_byte_list chunk, input bit pause);
        t_rx_item it;
        for (int i = 0; i < chunk.size(); i++) begin
            it.rx_byte = chunk[i];
            it.last    = (i == chunk.size() - 1);
            it.pause   = pause && (i == 0);
            rx_pending.insert(rx_pending.size(), it);
        end
    endtask

    // Build one frame with random content, at times too big or with trailing bytes
    task automatic build_frame(output t_byte_list fr);
        logic       masked;
        logic [6:0] code;
        logic [7:0] hi;
        logic [7:0] lo;
        int         plen;
        int         pick;
        int         tail;
        fr = {};
        fr.insert(fr.size(), 8'($urandom_range(255)));
        masked = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 6) begin
            code = LEN_TOO_BIG;
        end else if (pick < 20) begin
            code = LEN_EXT16;
        end else if (pick < 25) begin
            code = 7'($urandom_range(125));
        end else begin
            code = 7'($urandom_range(12));
        end
        fr.insert(fr.size(), {masked, code});
        plen = 0;
        if (code == LEN_EXT16) begin
            hi = ($urandom_range(19) == 0) ? 8'h01 : 8'h00;
            lo = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(16));
            fr.insert(fr.size(), hi);
            fr.insert(fr.size(), lo);
            plen = int'({hi, lo});
        end else if (code != LEN_TOO_BIG) begin
            plen = int'(code);
        end
        if (code != LEN_TOO_BIG) begin
            if (masked) begin
                repeat (4) fr.insert(fr.size(), 8'($urandom_range(255)));
            end
            repeat (plen) fr.insert(fr.size(), 8'($urandom_range(255)));
        end
        tail = ($urandom_range(2) == 0) ? int'($urandom_range(1, 3)) : 0;
        repeat (tail) fr.insert(fr.size(), 8'($urandom_range(255)));
    endtask

    // Fill the stimulus, then wait for the drain and give the verdict
    initial begin
        t_byte_list chunk;
        int         total;
        int         next_pause;
        int         cut;
        bit         pause;

        // Directed: too short, too big, truncations, empty, trailing, unmasked
        chunk = '{8'hFF};                                   add_chunk(chunk, 1'b0);
        chunk = '{8'h00, 8'h7F};                            add_chunk(chunk, 1'b0);
        chunk = '{8'h82, 8'hFF, 8'h55};                     add_chunk(chunk, 1'b0);
        chunk = '{8'h81, 8'h7E};                            add_chunk(chunk, 1'b0);
        chunk = '{8'h81, 8'hFE, 8'h00};                     add_chunk(chunk, 1'b0);
        chunk = '{8'h89, 8'h00};                            add_chunk(chunk, 1'b0);
        chunk = '{8'h8A, 8'h80, 8'h01, 8'h02, 8'h03};       add_chunk(chunk, 1'b0);
        chunk = '{8'h02, 8'h83, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h10, 8'h20};
        add_chunk(chunk, 1'b0);
        chunk = '{8'h81, 8'h01, 8'h41, 8'h00, 8'hFF};       add_chunk(chunk, 1'b0);

        // Random: mostly well-formed frames, some cut short, some noise
        total = 0;
        next_pause = 0;
        while (total < RAND_BYTES) begin
            pause = 1'b0;
            if (total >= next_pause) begin
                pause = 1'b1;
                next_pause += PAUSE_GAP;
            end
            build_frame(chunk);
            if ($urandom_range(99) < 8) begin
                cut = $urandom_range(chunk.size() - 1);
                chunk = chunk[0:cut];
            end else if ($urandom_range(99) < 7) begin
                chunk = {};
                repeat ($urandom_range(1, 5)) chunk.insert(chunk.size(), 8'($urandom_range(255)));
            end
            add_chunk(chunk, pause);
            total += chunk.size();
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending.size() != 0 || i_valid) @(posedge i_clk);
        while (decoded_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Offer bytes; hold each until taken, drain first where marked
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !byte_taken)) begin
            if (rx_pending.size() == 0) begin
                i_valid <= 1'b0;
            end else if (rx_pending[0].pause && decoded_words.size() != 0) begin
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
            end else begin
                next_item = rx_pending.pop_front();
                i_valid     <= 1'b1;
                i_rx_byte   <= next_item.rx_byte;
                i_chunk_end <= next_item.last;
            end
        end
    end

    // Stall the output at random, once for a long stretch
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (bytes_in >= HOLD_AT && !hold_done) begin
            i_ready <= 1'b0;
            stall_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check results, predict from accepted bytes, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (decoded_words.size() == 0) begin
                    report_error($sformatf("result with nothing pending, byte %02h",
                                           o_payload_byte));
                end else begin
                    want = decoded_words.pop_front();
                    if (o_payload_byte !== want.data)
                        report_error($sformatf("payload_byte %02h, want %02h",
                                               o_payload_byte, want.data));
                    if (o_byte_valid !== want.valid)
                        report_error($sformatf("byte_valid %0b, want %0b",
                                               o_byte_valid, want.valid));
                    if (o_final_flag !== want.fin)
                        report_error($sformatf("final_flag %0b, want %0b",
                                               o_final_flag, want.fin));
                    if (o_frame_opcode !== want.opcode)
                        report_error($sformatf("frame_opcode %0h, want %0h",
                                               o_frame_opcode, want.opcode));
                    if (o_status !== want.status)
                        report_error($sformatf("status %0d, want %0d",
                                               o_status, want.status));
                    if (o_frame_done !== want.done)
                        report_error($sformatf("frame_done %0b, want %0b",
                                               o_frame_done, want.done));
                end
            end
            if (i_valid && o_ready) begin
                decode_byte(i_rx_byte, i_chunk_end);
                bytes_in <= bytes_in + 1;
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WAIT_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
        byte_taken <= i_rst_n && i_valid && o_ready;
    end

endmodule
